### design/swrr_pkg.sv
package swrr_pkg;

	localparam logic [1:0] REQ_PICK    = 2'd0;
	localparam logic [1:0] REQ_DISABLE = 2'd1;
	localparam logic [1:0] REQ_ADD     = 2'd2;

	localparam logic [2:0] CFG_TARGET_COUNT = 3'd0;
	localparam logic [2:0] CFG_WEIGHT_0     = 3'd1;
	localparam logic [2:0] CFG_WEIGHT_3     = 3'd4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 48;
	localparam int WEIGHT_W    = 48;
	localparam int CUR_W       = 64;
	localparam int DELTA_W     = 32;
	localparam int COUNT_W     = 3;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 8;

	typedef struct packed {
		logic load_req;
		logic clear_scan;
		logic scan_step;
		logic apply;
		logic load_out;
	} swrr_cmd_t;

	typedef struct packed {
		logic is_pick;
		logic scan_none;
		logic scan_last;
		logic out_free;
	} swrr_status_t;

endpackage

### design/swrr_datapath.sv
module swrr_datapath #(
	parameter int NUM_TARGETS = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [swrr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [swrr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [swrr_pkg::S_TDATA_W-1:0]     s_tdata,
	input  swrr_pkg::swrr_cmd_t                cmd,
	output swrr_pkg::swrr_status_t             status,
	input  logic                               m_tready,
	output logic                               m_tvalid,
	output logic [swrr_pkg::M_TDATA_W-1:0]     m_tdata
);

	localparam int IW = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;

	logic [swrr_pkg::COUNT_W-1:0]  count_q;
	logic [swrr_pkg::WEIGHT_W-1:0] weight_q [NUM_TARGETS];
	logic [swrr_pkg::CUR_W-1:0]    cur_q    [NUM_TARGETS];
	logic [NUM_TARGETS-1:0]        en_q;

	logic [1:0]                    req_q;
	logic [1:0]                    sel_q;
	logic [swrr_pkg::DELTA_W-1:0]  delta_q;

	logic [swrr_pkg::COUNT_W-1:0]  cnt_q;
	logic [swrr_pkg::CUR_W-1:0]    total_q;
	logic [swrr_pkg::CUR_W-1:0]    best_w_q;
	logic [IW-1:0]                 best_q;
	logic                          found_q;

	logic [swrr_pkg::COUNT_W-1:0]  n_eff;
	logic [IW-1:0]                 scan_idx;
	logic [IW-1:0]                 sel_idx;
	logic [swrr_pkg::CUR_W-1:0]    scan_sum;
	logic [swrr_pkg::CUR_W-1:0]    scan_w;
	logic                          take;
	logic                          sel_ok;
	logic [swrr_pkg::CFG_INDEX_W-1:0] cfg_t;
	logic                          cfg_w_ok;

	assign n_eff    = (count_q > swrr_pkg::COUNT_W'(NUM_TARGETS))
	                  ? swrr_pkg::COUNT_W'(NUM_TARGETS) : count_q;
	assign scan_idx = cnt_q[IW-1:0];
	assign sel_idx  = IW'(sel_q);
	assign scan_w   = {{(swrr_pkg::CUR_W-swrr_pkg::WEIGHT_W){1'b0}}, weight_q[scan_idx]};
	assign scan_sum = cur_q[scan_idx] + scan_w;
	assign take     = en_q[scan_idx] &&
	                  (!found_q || ($signed(scan_sum) > $signed(best_w_q)));
	assign sel_ok   = {1'b0, sel_q} < n_eff;
	assign cfg_t    = cfg_index - swrr_pkg::CFG_WEIGHT_0;
	assign cfg_w_ok = (cfg_index >= swrr_pkg::CFG_WEIGHT_0) &&
	                  (cfg_index <= swrr_pkg::CFG_WEIGHT_3) &&
	                  (cfg_t < swrr_pkg::CFG_INDEX_W'(NUM_TARGETS));

	assign status.is_pick   = (req_q == swrr_pkg::REQ_PICK);
	assign status.scan_none = (n_eff == '0);
	assign status.scan_last = (cnt_q == n_eff - swrr_pkg::COUNT_W'(1));
	assign status.out_free  = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			en_q    <= '1;
			for (int i = 0; i < NUM_TARGETS; i++) begin
				weight_q[i] <= '0;
				cur_q[i]    <= '0;
			end
		end else begin
			if (cfg_we && cfg_index == swrr_pkg::CFG_TARGET_COUNT) begin
				count_q <= cfg_data[swrr_pkg::COUNT_W-1:0];
			end
			for (int i = 0; i < NUM_TARGETS; i++) begin
				if (cfg_we && cfg_w_ok && cfg_t == swrr_pkg::CFG_INDEX_W'(i)) begin
					weight_q[i] <= cfg_data[swrr_pkg::WEIGHT_W-1:0];
					cur_q[i]    <= {{(swrr_pkg::CUR_W-swrr_pkg::WEIGHT_W){1'b0}},
					                cfg_data[swrr_pkg::WEIGHT_W-1:0]};
					en_q[i]     <= 1'b1;
				end
			end
			if (cmd.scan_step && en_q[scan_idx]) begin
				cur_q[scan_idx] <= scan_sum;
			end
			if (cmd.apply) begin
				case (req_q)
					swrr_pkg::REQ_PICK: begin
						if (found_q) begin
							cur_q[best_q] <= cur_q[best_q] - total_q;
						end
					end
					swrr_pkg::REQ_DISABLE: begin
						if (sel_ok) begin
							en_q[sel_idx] <= 1'b0;
						end
					end
					swrr_pkg::REQ_ADD: begin
						if (sel_ok) begin
							cur_q[sel_idx] <= cur_q[sel_idx] +
								{{(swrr_pkg::CUR_W-swrr_pkg::DELTA_W){delta_q[swrr_pkg::DELTA_W-1]}},
								 delta_q};
							en_q[sel_idx]  <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q   <= s_tdata[1:0];
			sel_q   <= s_tdata[3:2];
			delta_q <= s_tdata[35:4];
		end
		if (cmd.clear_scan) begin
			cnt_q    <= '0;
			total_q  <= '0;
			found_q  <= 1'b0;
			best_q   <= '0;
			best_w_q <= '0;
		end else if (cmd.scan_step) begin
			cnt_q <= cnt_q + swrr_pkg::COUNT_W'(1);
			if (en_q[scan_idx]) begin
				total_q <= total_q + scan_w;
			end
			if (take) begin
				found_q  <= 1'b1;
				best_q   <= scan_idx;
				best_w_q <= scan_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata <= {{(swrr_pkg::M_TDATA_W-3){1'b0}},
			            ((status.is_pick && found_q) ? 2'(best_q) : 2'd0),
			            (status.is_pick && found_q)};
		end
	end

endmodule

### design/swrr_ctrl.sv
module swrr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  swrr_pkg::swrr_status_t status,
	output swrr_pkg::swrr_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_req   = 1'b1;
					cmd.clear_scan = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.is_pick && !status.scan_none) begin
					cmd.scan_step = 1'b1;
					if (status.scan_last) begin
						state_d = ST_APPLY;
					end
				end else begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.out_free)
		else $error("result loaded over an untaken result");

	a_scan_only_pick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> status.is_pick)
		else $error("scan step on a non-pick request");

	a_apply_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> (state_q == ST_DONE) && !s_tready)
		else $error("apply not followed by result stage");

	a_accept_then_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_SCAN))
		else $error("accepted transaction did not start a scan");

endmodule

### design/smooth_weighted_round_robin.sv
// channel   dir  handshake          payload
// s_axis    in   s_tvalid/s_tready  s_tdata: req_type, target_sel, weight_delta
// m_axis    out  m_tvalid/m_tready  m_tdata: pick_valid, pick_index
// cfg       in   cfg_we             cfg_index, cfg_data (48 bit)
//
// a pick scans n targets, then applies and loads its result, n the effective count:
// one target per cycle through the shared 64-bit add and signed compare
// other requests and picks with target count zero skip the scan
// no new request is accepted until the last one has loaded its result
// reset: running weights zero, all targets enabled, target count zero
// a stalled result waits in its register; one more request runs, then the input stalls
module smooth_weighted_round_robin #(
	parameter int NUM_TARGETS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [swrr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [swrr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// req_type[1:0], target_sel[3:2], weight_delta[35:4], zero pad
	input  logic [swrr_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// pick_valid[0], pick_index[2:1], zero pad
	output logic [swrr_pkg::M_TDATA_W-1:0]    m_tdata
);

	swrr_pkg::swrr_cmd_t    cmd;
	swrr_pkg::swrr_status_t status;

	swrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	swrr_datapath #(
		.NUM_TARGETS (NUM_TARGETS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule
